// ===== rtl/cls_pkg.sv =====
// Shared types and codes for the circular list value store.
// Holds the request and response payload structs, the opcode and status codes.
// No dependencies.
package cls_pkg;

   localparam int VALUE_W = 32;
   localparam int POS_W   = 16;

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_GET    = 2'd2;
   localparam logic [1:0] OP_NOP    = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   typedef struct packed {
      logic [1:0]                opcode;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] read_data;
      logic [1:0]                status;
   } rsp_type;

endpackage

// ===== rtl/cls_ram.sv =====
// Entry store of the circular list value store.
// Simple dual-port synchronous memory, one write and one registered read per cycle.
// No package dependencies.
module cls_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/cls_mod.sv =====
// Iterative remainder unit of the circular list value store.
// Restoring division, one dividend bit per cycle; uses cls_pkg for the dividend width.
// The divisor must be non-zero; the result is flagged by a one-cycle done pulse.
module cls_mod #(
   parameter int CW = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [cls_pkg::POS_W-1:0] dividend,
   input  logic [CW-1:0]            divisor,
   output logic                     done,
   output logic [CW-1:0]            remainder
);

   localparam int SW = $clog2(cls_pkg::POS_W);

   logic [cls_pkg::POS_W-1:0] num_ff, num_in;
   logic [CW-1:0]             div_ff, div_in;
   logic [CW-1:0]             rem_ff, rem_in;
   logic [SW-1:0]             step_ff, step_in;
   logic                      run_ff, run_in;
   logic                      done_ff, done_in;
   logic [CW:0]               trial;

   always_comb begin
      num_in  = num_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, num_ff[cls_pkg::POS_W-1]};
      if (start) begin
         num_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = CW'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[CW-1:0];
         end
         num_in  = {num_ff[cls_pkg::POS_W-2:0], 1'b0};
         step_in = step_ff + SW'(1);
         if (step_ff == SW'(cls_pkg::POS_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      num_ff  <= num_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/circular_list_value_store.sv =====
// Top level of the circular list value store: control sequencer and count register.
// Instantiates cls_ram (entry store) and cls_mod (remainder unit); uses cls_pkg.
//
//   channel  | ports                      | transfer happens when
//   ---------+----------------------------+-------------------------------
//   request  | start, busy, req_item      | start high and busy low
//   response | rsp_valid, rsp_item        | every cycle rsp_valid is high
//
// Append and the no-operation code are answered straight from the idle state. A get
// loads the bit-serial remainder unit, lets it run over the position, issues one
// memory read and registers the response. A remove that matches a later entry
// makes one pass over the memory, one entry per cycle, takes in the last read and
// then registers the response. With no later match the head is then read and
// compared; if it matches, a second pass shifts the list down. Reset is
// synchronous and empties the list at once; the memory holds no valid bits and
// needs no clearing pass. The receiver cannot stall: each response is shown for
// exactly one cycle.
module circular_list_value_store #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cls_pkg::req_type req_item,
   output logic             rsp_valid,
   output cls_pkg::rsp_type rsp_item
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   // One-hot sequencer states.
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_DIV  = 5'b00010,
      S_GRD  = 5'b00100,
      S_SCAN = 5'b01000,
      S_HEAD = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   cls_pkg::req_type      req_ff, req_in;
   cls_pkg::rsp_type      rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic                  pend_ff, pend_in;
   logic [AW-1:0]         pend_addr_ff, pend_addr_in;
   logic                  found_ff, found_in;

   logic                          ram_we;
   logic [AW-1:0]                 ram_waddr;
   logic [cls_pkg::VALUE_W-1:0]   ram_wdata;
   logic [AW-1:0]                 ram_raddr;
   logic [cls_pkg::VALUE_W-1:0]   ram_rdata;

   logic          mod_start;
   logic          mod_done;
   logic [CW-1:0] mod_rem;
   logic [CW-1:0] get_idx;
   logic          accept;
   logic          rd_match;

   assign accept   = start && (state_ff == S_IDLE);
   assign rd_match = (ram_rdata == $unsigned(req_ff.value));

   // Position p from the head maps to slot (p - 1) mod count, which is
   // count - 1 when p is a multiple of count.
   assign get_idx = (mod_rem == '0) ? (count_ff - CW'(1)) : (mod_rem - CW'(1));

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      found_in     = found_ff;
      ram_we       = 1'b0;
      ram_waddr    = count_ff[AW-1:0];
      ram_wdata    = $unsigned(req_item.value);
      ram_raddr    = idx_ff[AW-1:0];
      mod_start    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in             = req_item;
               rsp_in.read_data   = '0;
               rsp_in.status      = cls_pkg::ST_OK;
               case (req_item.opcode)
                  cls_pkg::OP_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == CW'(DEPTH)) begin
                        rsp_in.status = cls_pkg::ST_FULL;
                     end else begin
                        ram_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  cls_pkg::OP_REMOVE: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = cls_pkg::ST_EMPTY;
                     end else begin
                        // The search starts at the second entry.
                        idx_in   = CW'(1);
                        pend_in  = 1'b0;
                        found_in = 1'b0;
                        state_in = S_SCAN;
                     end
                  end
                  cls_pkg::OP_GET: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = cls_pkg::ST_EMPTY;
                     end else begin
                        mod_start = 1'b1;
                        state_in  = S_DIV;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         S_DIV: begin
            if (mod_done) begin
               ram_raddr = get_idx[AW-1:0];
               state_in  = S_GRD;
            end
         end

         S_GRD: begin
            rsp_valid_in     = 1'b1;
            rsp_in.read_data = $signed(ram_rdata);
            rsp_in.status    = cls_pkg::ST_OK;
            state_in         = S_IDLE;
         end

         S_SCAN: begin
            // A read issued last cycle returns now. Before a match it is
            // compared; after a match it moves down one slot to close the gap.
            if (pend_ff) begin
               if (found_ff) begin
                  ram_we    = 1'b1;
                  ram_waddr = pend_addr_ff - AW'(1);
                  ram_wdata = ram_rdata;
               end else if (rd_match) begin
                  found_in = 1'b1;
               end
            end
            if (idx_ff < count_ff) begin
               pend_in      = 1'b1;
               pend_addr_in = idx_ff[AW-1:0];
               idx_in       = idx_ff + CW'(1);
            end else begin
               pend_in = 1'b0;
            end
            if (!pend_ff && (idx_ff >= count_ff)) begin
               if (found_ff) begin
                  count_in         = count_ff - CW'(1);
                  rsp_valid_in     = 1'b1;
                  rsp_in.read_data = '0;
                  rsp_in.status    = cls_pkg::ST_OK;
                  state_in         = S_IDLE;
               end else begin
                  // No match among the later entries: check the head last.
                  ram_raddr = '0;
                  state_in  = S_HEAD;
               end
            end
         end

         S_HEAD: begin
            if (rd_match) begin
               // Head matches: a second pass shifts every later entry down.
               found_in = 1'b1;
               idx_in   = CW'(1);
               pend_in  = 1'b0;
               state_in = S_SCAN;
            end else begin
               rsp_valid_in     = 1'b1;
               rsp_in.read_data = '0;
               rsp_in.status    = cls_pkg::ST_NOTFOUND;
               state_in         = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
      end
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
      idx_ff       <= idx_in;
      pend_addr_ff <= pend_addr_in;
   end

   cls_ram #(
      .DEPTH (DEPTH),
      .WIDTH (cls_pkg::VALUE_W),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   cls_mod #(
      .CW (CW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (req_item.position),
      .divisor   (count_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
